### rtl/gsp_pkg.sv
// Shared constants, codes and types of the grid sample placement unit.
package gsp_pkg;

  // Widths of the raster address, the grid dimensions and the data words
  localparam int ADDR_BITS     = 24;
  localparam int DIM_BITS      = 14;
  localparam int ORDER_BITS    = 3;
  localparam int VALUE_BITS    = 64;
  localparam int STATUS_BITS   = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 14;
  localparam int TIN_BITS      = 2;
  localparam int PROD_BITS     = 2 * DIM_BITS;
  localparam int WIDE_BITS     = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;
  localparam int DIV_CNT_BITS  = $clog2(ADDR_BITS);

  // Arrangement orders; any other code places rows from the bottom
  localparam logic [ORDER_BITS-1:0] ORD_COL_BOTTOM  = 3'd1;
  localparam logic [ORDER_BITS-1:0] ORD_ROW_MAJOR   = 3'd2;
  localparam logic [ORDER_BITS-1:0] ORD_COL_TOP     = 3'd3;
  localparam logic [ORDER_BITS-1:0] ORD_ROWS_BOTTOM = 3'd4;

  // Status codes
  localparam logic [STATUS_BITS-1:0] STAT_RUNNING  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_TOO_MANY = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_TOO_FEW  = 2'd3;

  // Commands
  localparam logic CMD_TOKEN = 1'b0;
  localparam logic CMD_END   = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COORDS    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRECISION = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT    = 3'd4;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 14'd1;

  typedef struct packed {
    logic [ORDER_BITS-1:0] order;
    logic                  coords;
    logic                  precision;
    logic [DIM_BITS-1:0]   width;
    logic [DIM_BITS-1:0]   height;
  } gsp_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAP,
    S_DECIDE,
    S_DIV,
    S_MUL,
    S_WB
  } gsp_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic decide;
    logic div_step;
    logic mul;
    logic wb;
  } gsp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic place;
    logic div_last;
  } gsp_stat_t;

endpackage

### rtl/gsp_cfg_regs.sv
// Configuration register file of the grid sample placement unit.
module gsp_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gsp_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [gsp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  output gsp_pkg::gsp_cfg_t                   cfg_o
);

  gsp_pkg::gsp_cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        gsp_pkg::REG_ORDER:     cfg_d.order     = cfg_wdata_i[gsp_pkg::ORDER_BITS-1:0];
        gsp_pkg::REG_COORDS:    cfg_d.coords    = cfg_wdata_i[0];
        gsp_pkg::REG_PRECISION: cfg_d.precision = cfg_wdata_i[0];
        gsp_pkg::REG_WIDTH:     cfg_d.width     = cfg_wdata_i[gsp_pkg::DIM_BITS-1:0];
        gsp_pkg::REG_HEIGHT:    cfg_d.height    = cfg_wdata_i[gsp_pkg::DIM_BITS-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.order     <= gsp_pkg::ORD_ROW_MAJOR;
      cfg_q.coords    <= 1'b0;
      cfg_q.precision <= 1'b0;
      cfg_q.width     <= gsp_pkg::DIM_RESET;
      cfg_q.height    <= gsp_pkg::DIM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/gsp_ctrl.sv
// Controller state machine: sequences decide, divide and multiply if writing, and output.
module gsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  gsp_pkg::gsp_stat_t   stat_i,
  output gsp_pkg::gsp_cmd_t    cmd_o
);

  gsp_pkg::gsp_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  // Output slot can take a new result when empty or emptying now
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gsp_pkg::S_IDLE:   if (in_valid_i) state_d = gsp_pkg::S_CAP;
      gsp_pkg::S_CAP:    state_d = gsp_pkg::S_DECIDE;
      gsp_pkg::S_DECIDE: state_d = stat_i.place ? gsp_pkg::S_DIV : gsp_pkg::S_WB;
      gsp_pkg::S_DIV:    if (stat_i.div_last) state_d = gsp_pkg::S_MUL;
      gsp_pkg::S_MUL:    state_d = gsp_pkg::S_WB;
      gsp_pkg::S_WB:     if (slot_free) state_d = gsp_pkg::S_IDLE;
      default:           state_d = gsp_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gsp_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      gsp_pkg::S_DECIDE: cmd_o.decide   = 1'b1;
      gsp_pkg::S_DIV:    cmd_o.div_step = 1'b1;
      gsp_pkg::S_MUL:    cmd_o.mul      = 1'b1;
      gsp_pkg::S_WB:     cmd_o.wb       = slot_free;
      default:           cmd_o          = '0;
    endcase
  end

  // Hold the result valid until the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.wb) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_wb_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gsp_pkg::S_WB))
    else $error("result valid raised outside write-back");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result valid dropped before its transfer");

endmodule

### rtl/gsp_dp.sv
// Datapath: node bookkeeping, serial divider, address multiply and output register.
module gsp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gsp_pkg::gsp_cfg_t                   cfg_i,
  input  gsp_pkg::gsp_cmd_t                   cmd_i,
  output gsp_pkg::gsp_stat_t                  stat_o,
  input  logic                                command_i,
  input  logic [gsp_pkg::VALUE_BITS-1:0]      token_value_i,
  output logic                                write_enable_o,
  output logic [gsp_pkg::ADDR_BITS-1:0]       write_address_o,
  output logic [gsp_pkg::VALUE_BITS-1:0]      write_value_o,
  output logic [gsp_pkg::STATUS_BITS-1:0]     status_o
);

  localparam int AB = gsp_pkg::ADDR_BITS;
  localparam int DB = gsp_pkg::DIM_BITS;
  localparam int PB = gsp_pkg::PROD_BITS;
  localparam int WB = gsp_pkg::WIDE_BITS;

  // Position of the next token within a node
  localparam logic [gsp_pkg::TIN_BITS-1:0] TIN_FIRST = 2'd0;
  localparam logic [gsp_pkg::TIN_BITS-1:0] TIN_LAT   = 2'd1;
  localparam logic [gsp_pkg::TIN_BITS-1:0] TIN_VALUE = 2'd2;
  localparam logic [gsp_pkg::TIN_BITS-1:0] TIN_PREC  = 2'd3;

  localparam logic [WB-1:0] CAP_LIMIT = (WB'(1) << AB) - WB'(1);

  // Node state
  logic [AB-1:0]                     cnt_q, cnt_d;
  logic [gsp_pkg::TIN_BITS-1:0]      tin_q, tin_d;
  logic                              stop_q, stop_d;
  logic [gsp_pkg::STATUS_BITS-1:0]   fin_q, fin_d;

  // Captured input item
  logic                              in_cmd_q;
  logic [gsp_pkg::VALUE_BITS-1:0]    tok_q;

  // Capacity
  logic [PB-1:0]                     cap_prod_q;
  logic [WB-1:0]                     cap_wide;
  logic [AB-1:0]                     cap;

  // Decision
  logic                              dec_we;
  logic [gsp_pkg::STATUS_BITS-1:0]   dec_st;
  logic                              res_we_q;
  logic [gsp_pkg::STATUS_BITS-1:0]   res_st_q;
  logic [AB-1:0]                     res_c_q;

  // Divider
  logic [DB-1:0]                     w_eff, h_eff;
  logic [DB-1:0]                     div_q, rem_q;
  logic [AB-1:0]                     quo_q;
  logic [gsp_pkg::DIV_CNT_BITS-1:0]  dcnt_q;
  logic [DB:0]                       trial, diff;
  logic                              ge;

  // Multiply and add
  logic [AB-1:0]                     mul_a;
  logic [AB-1:0]                     add_b;
  logic [PB-1:0]                     mul_q;
  logic [AB-1:0]                     addb_q;
  logic [WB-1:0]                     sum;
  logic [AB-1:0]                     addr;

  // Output register
  logic                              out_we_q;
  logic [AB-1:0]                     out_addr_q;
  logic [gsp_pkg::VALUE_BITS-1:0]    out_val_q;
  logic [gsp_pkg::STATUS_BITS-1:0]   out_st_q;

  assign w_eff = (cfg_i.width  == '0) ? gsp_pkg::DIM_RESET : cfg_i.width;
  assign h_eff = (cfg_i.height == '0) ? gsp_pkg::DIM_RESET : cfg_i.height;

  // Capacity: width times height, clipped to the address space
  always_ff @(posedge clk_i) begin
    cap_prod_q <= PB'(cfg_i.width) * PB'(cfg_i.height);
  end

  assign cap_wide = (WB'(cap_prod_q) > CAP_LIMIT) ? CAP_LIMIT : WB'(cap_prod_q);
  assign cap      = cap_wide[AB-1:0];

  // Work out what this token does to the node state
  always_comb begin
    dec_we = 1'b0;
    dec_st = gsp_pkg::STAT_RUNNING;
    cnt_d  = cnt_q;
    tin_d  = tin_q;
    stop_d = stop_q;
    fin_d  = fin_q;
    if (stop_q) begin
      dec_st = fin_q;
    end else if (in_cmd_q == gsp_pkg::CMD_END) begin
      dec_st = (cnt_q == cap) ? gsp_pkg::STAT_OK : gsp_pkg::STAT_TOO_FEW;
      stop_d = 1'b1;
      fin_d  = dec_st;
    end else if (tin_q == TIN_FIRST) begin
      if (cnt_q >= cap) begin
        dec_st = gsp_pkg::STAT_TOO_MANY;
        stop_d = 1'b1;
        fin_d  = dec_st;
      end else begin
        dec_we = !cfg_i.coords;
        if (!cfg_i.coords && !cfg_i.precision) begin
          cnt_d = cnt_q + AB'(1);
        end else begin
          tin_d = TIN_LAT;
        end
      end
    end else if (cfg_i.coords && tin_q == TIN_LAT) begin
      tin_d = TIN_VALUE;
    end else if (cfg_i.coords && tin_q == TIN_VALUE) begin
      dec_we = 1'b1;
      if (!cfg_i.precision) begin
        cnt_d = cnt_q + AB'(1);
        tin_d = TIN_FIRST;
      end else begin
        tin_d = TIN_PREC;
      end
    end else begin
      tin_d = TIN_FIRST;
      cnt_d = cnt_q + AB'(1);
    end
  end

  assign stat_o.place = dec_we;

  // Advance node state once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      tin_q  <= TIN_FIRST;
      stop_q <= 1'b0;
      fin_q  <= gsp_pkg::STAT_RUNNING;
    end else if (cmd_i.decide) begin
      cnt_q  <= cnt_d;
      tin_q  <= tin_d;
      stop_q <= stop_d;
      fin_q  <= fin_d;
    end
  end

  // Capture the input transfer and the decision
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_cmd_q <= command_i;
      tok_q    <= token_value_i;
    end
    if (cmd_i.decide) begin
      res_we_q <= dec_we;
      res_st_q <= dec_st;
      res_c_q  <= cnt_q;
    end
  end

  // Restoring divider step: one quotient bit per cycle
  assign trial = {rem_q, quo_q[AB-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      quo_q  <= cnt_q;
      rem_q  <= '0;
      dcnt_q <= '0;
      div_q  <= (cfg_i.order == gsp_pkg::ORD_COL_BOTTOM ||
                 cfg_i.order == gsp_pkg::ORD_COL_TOP) ? h_eff : w_eff;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[AB-2:0], ge};
      rem_q  <= ge ? diff[DB-1:0] : trial[DB-1:0];
      dcnt_q <= dcnt_q + gsp_pkg::DIV_CNT_BITS'(1);
    end
  end

  assign stat_o.div_last = (dcnt_q == gsp_pkg::DIV_CNT_BITS'(AB - 1));

  // Select row and column terms of the address; the row term wraps at the address width
  always_comb begin
    case (cfg_i.order)
      gsp_pkg::ORD_COL_BOTTOM: begin
        mul_a = AB'(h_eff - DB'(1) - rem_q);
        add_b = quo_q;
      end
      gsp_pkg::ORD_COL_TOP: begin
        mul_a = AB'(rem_q);
        add_b = quo_q;
      end
      default: begin
        mul_a = AB'(h_eff) - AB'(1) - quo_q;
        add_b = AB'(rem_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      mul_q  <= PB'(mul_a) * PB'(w_eff);
      addb_q <= add_b;
    end
  end

  // Final address
  assign sum  = WB'(mul_q) + WB'(addb_q);
  assign addr = (cfg_i.order == gsp_pkg::ORD_ROW_MAJOR) ? res_c_q : sum[AB-1:0];

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      out_we_q   <= res_we_q;
      out_addr_q <= res_we_q ? addr : '0;
      out_val_q  <= res_we_q ? tok_q : '0;
      out_st_q   <= res_st_q;
    end
  end

  assign write_enable_o  = out_we_q;
  assign write_address_o = out_addr_q;
  assign write_value_o   = out_val_q;
  assign status_o        = out_st_q;

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("block left the stopped state");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.decide |=> $stable(cnt_q))
    else $error("node count moved outside decide");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

endmodule

### rtl/grid_sample_placement_unit.sv
// Top level of the grid sample placement unit.
// Takes one converted token per input transfer and returns one result per token: a raster write
// (enable, row-major address, value word) and a status. A token that writes a height value goes
// through capture, decide, divide, multiply and write-back before the next input transfer; a
// token that writes nothing or an end-of-data command skips divide and multiply. The restoring
// divider produces one quotient bit per cycle over the 24-bit node index. The result sits in an
// output register, so the next input transfer does not wait for the previous result to be taken.
// Configuration must be written through the plain write port only while no item is in flight;
// the block itself does not enforce this. After a too-many-values error or an end-of-data
// command the block answers every item with no write and the latched status until reset.
module grid_sample_placement_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gsp_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [gsp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [gsp_pkg::VALUE_BITS-1:0]      token_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                write_enable_o,
  output logic [gsp_pkg::ADDR_BITS-1:0]       write_address_o,
  output logic [gsp_pkg::VALUE_BITS-1:0]      write_value_o,
  output logic [gsp_pkg::STATUS_BITS-1:0]     status_o
);

  gsp_pkg::gsp_cfg_t  cfg;
  gsp_pkg::gsp_cmd_t  cmd;
  gsp_pkg::gsp_stat_t stat;

  gsp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gsp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (command_i),
    .token_value_i   (token_value_i),
    .write_enable_o  (write_enable_o),
    .write_address_o (write_address_o),
    .write_value_o   (write_value_o),
    .status_o        (status_o)
  );

endmodule

### sim/gsp_placement_checker.sv
// Checker that predicts and compares the raster writes of the grid sample placement unit.
`timescale 1ns / 1ps
module gsp_placement_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gsp_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [gsp_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              command_i,
  input  logic [gsp_pkg::VALUE_BITS-1:0]    token_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              write_enable_i,
  input  logic [gsp_pkg::ADDR_BITS-1:0]     write_address_i,
  input  logic [gsp_pkg::VALUE_BITS-1:0]    write_value_i,
  input  logic [gsp_pkg::STATUS_BITS-1:0]   status_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output logic [gsp_pkg::ADDR_BITS-1:0]     nodes_o,
  output logic [gsp_pkg::TIN_BITS-1:0]      token_pos_o
);
  import gsp_pkg::*;

  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic                   we;
    logic [ADDR_BITS-1:0]   addr;
    logic [VALUE_BITS-1:0]  value;
    logic [STATUS_BITS-1:0] status;
  } placement_t;

  // Shadow copy of the configuration registers
  logic [ORDER_BITS-1:0]  arr_order;
  logic                   has_coords;
  logic                   has_prec;
  logic [DIM_BITS-1:0]    grid_w;
  logic [DIM_BITS-1:0]    grid_h;

  // Shadow copy of the placement state
  logic [ADDR_BITS-1:0]   nodes_placed;
  logic [TIN_BITS-1:0]    token_pos;
  logic                   halted;
  logic [STATUS_BITS-1:0] latched_status;

  placement_t placements_due[$];
  int         mismatches;

  // Number of nodes the grid holds, clipped to the address space
  function automatic longint unsigned grid_capacity();
    longint unsigned w, h, total, lim;
    w     = grid_w;
    h     = grid_h;
    total = w * h;
    lim   = (64'd1 << ADDR_BITS) - 1;
    return (total > lim) ? lim : total;
  endfunction

  // Row-major raster index of node c under the current arrangement order
  function automatic logic [ADDR_BITS-1:0] raster_index(longint unsigned c);
    longint unsigned w, h, r;
    w = (grid_w == '0) ? 1 : grid_w;
    h = (grid_h == '0) ? 1 : grid_h;
    case (arr_order)
      ORD_COL_BOTTOM: r = (h - 1 - (c % h)) * w + (c / h);
      ORD_ROW_MAJOR:  r = c;
      ORD_COL_TOP:    r = (c % h) * w + (c / h);
      default:        r = (h - 1 - (c / w)) * w + (c % w);
    endcase
    return r[ADDR_BITS-1:0];
  endfunction

  // Advance the shadow state by one token or command and return its result
  function automatic placement_t place_token(logic cmd, logic [VALUE_BITS-1:0] tok);
    placement_t      res;
    longint unsigned cap;
    res = '0;
    cap = grid_capacity();
    if (halted) begin
      res.status = latched_status;
    end else if (cmd == CMD_END) begin
      res.status     = (longint'(nodes_placed) == cap) ? STAT_OK : STAT_TOO_FEW;
      halted         = 1'b1;
      latched_status = res.status;
    end else if (token_pos == '0) begin
      if (longint'(nodes_placed) >= cap) begin
        res.status     = STAT_TOO_MANY;
        halted         = 1'b1;
        latched_status = res.status;
      end else begin
        if (!has_coords) begin
          res.we    = 1'b1;
          res.addr  = raster_index(nodes_placed);
          res.value = tok;
        end
        if (!has_coords && !has_prec) nodes_placed = nodes_placed + 1'b1;
        else token_pos = 2'd1;
      end
    end else if (has_coords && token_pos < 2'd2) begin
      token_pos = token_pos + 1'b1;
    end else if (has_coords && token_pos == 2'd2) begin
      res.we    = 1'b1;
      res.addr  = raster_index(nodes_placed);
      res.value = tok;
      if (!has_prec) begin
        nodes_placed = nodes_placed + 1'b1;
        token_pos    = '0;
      end else begin
        token_pos = 2'd3;
      end
    end else begin
      // trailing precision token closes the node
      token_pos    = '0;
      nodes_placed = nodes_placed + 1'b1;
    end
    return res;
  endfunction

  task automatic report(string what, logic [VALUE_BITS-1:0] exp, logic [VALUE_BITS-1:0] act);
    if (mismatches < REPORT_LIMIT)
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp, act);
    mismatches++;
  endtask

  // Track config writes, compare each result transfer, queue a prediction per input transfer
  always @(posedge clk_i or negedge rst_ni) begin : watch
    placement_t seen, due;
    if (!rst_ni) begin
      arr_order      = ORD_ROW_MAJOR;
      has_coords     = 1'b0;
      has_prec       = 1'b0;
      grid_w         = DIM_RESET;
      grid_h         = DIM_RESET;
      nodes_placed   = '0;
      token_pos      = '0;
      halted         = 1'b0;
      latched_status = STAT_RUNNING;
      mismatches     = 0;
      placements_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ORDER:     arr_order  = cfg_wdata_i[ORDER_BITS-1:0];
          REG_COORDS:    has_coords = cfg_wdata_i[0];
          REG_PRECISION: has_prec   = cfg_wdata_i[0];
          REG_WIDTH:     grid_w     = cfg_wdata_i[DIM_BITS-1:0];
          REG_HEIGHT:    grid_h     = cfg_wdata_i[DIM_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        seen = {write_enable_i, write_address_i, write_value_i, status_i};
        if (placements_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected result: expected none, actual %0h", $time, seen);
          mismatches++;
        end else begin
          due = placements_due.pop_front();
          if (seen.we !== due.we) report("write_enable", due.we, seen.we);
          if (seen.addr !== due.addr) report("write_address", due.addr, seen.addr);
          if (seen.value !== due.value) report("write_value", due.value, seen.value);
          if (seen.status !== due.status) report("status", due.status, seen.status);
        end
      end
      if (in_valid_i && in_ready_i)
        placements_due.push_back(place_token(command_i, token_value_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= placements_due.size();
    nodes_o      <= nodes_placed;
    token_pos_o  <= token_pos;
  end

endmodule

### sim/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the grid sample placement unit.
`timescale 1ns / 1ps
module tb;
  import gsp_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int ITEM_TARGET  = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PERCENT = 30;
  localparam int HEADROOM     = 256;
  localparam int QUIET_PHASE  = 3;
  localparam int HOLD_PHASE   = 1;

  // Arrangement codes outside the named set; the block treats them as rows from bottom
  localparam logic [ORDER_BITS-1:0]   ORD_CODE_ZERO = 3'd0;
  localparam logic [ORDER_BITS-1:0]   ORD_CODE_TOP  = 3'd7;
  localparam logic [CFG_IDX_BITS-1:0] REG_NONE      = 3'd7;
  localparam logic [DIM_BITS-1:0]     DIM_MAX       = '1;

  typedef enum int { END_EXACT, END_SHORT, END_OVERFLOW, END_ZERO_DIM } ending_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     command_i;
  logic [VALUE_BITS-1:0]    token_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     write_enable_o;
  logic [ADDR_BITS-1:0]     write_address_o;
  logic [VALUE_BITS-1:0]    write_value_o;
  logic [STATUS_BITS-1:0]   status_o;

  int                       fail_count;
  int                       pending;
  logic [ADDR_BITS-1:0]     nodes_seen;
  logic [TIN_BITS-1:0]      pos_seen;

  logic                     quiet;
  logic                     backpressure_req;
  logic                     cur_coords;
  logic                     cur_prec;
  int                       items_sent;
  int                       cycles;

  grid_sample_placement_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .token_value_i,
    .out_valid_o, .out_ready_i,
    .write_enable_o, .write_address_o, .write_value_o, .status_o
  );

  gsp_placement_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .token_value_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .write_enable_i(write_enable_o), .write_address_i(write_address_o),
    .write_value_i(write_value_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .nodes_o(nodes_seen), .token_pos_o(pos_seen)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // End the run if it hangs
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, one long hold-off once requested
  initial begin : result_sink
    logic held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (backpressure_req && !held) begin
        out_ready_i <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk_i);
        held = 1'b1;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  function automatic logic [VALUE_BITS-1:0] token_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ORDER_BITS-1:0] random_order();
    if ($urandom_range(0, 3) == 0) return ORDER_BITS'($urandom_range(0, 7));
    return ORDER_BITS'($urandom_range(1, 4));
  endfunction

  function automatic int node_tokens();
    return (cur_coords ? 2 : 0) + 1 + (cur_prec ? 1 : 0);
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(logic cmd, logic [VALUE_BITS-1:0] tok);
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    token_value_i <= tok;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_tokens(int count);
    for (int i = 0; i < count; i++) send_item(CMD_TOKEN, token_word());
  endtask

  // Drop valid and wait until every result is back and the block takes input again
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || !in_ready_o);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Program all registers; unused upper bits of the narrow ones carry noise
  task automatic set_grid(logic [ORDER_BITS-1:0] ord, logic coords, logic prec,
                          logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
    logic [CFG_DATA_BITS-1:0] noise;
    wait_idle();
    noise = CFG_DATA_BITS'($urandom);
    write_reg(REG_ORDER, {noise[CFG_DATA_BITS-1:ORDER_BITS], ord});
    noise = CFG_DATA_BITS'($urandom);
    write_reg(REG_COORDS, {noise[CFG_DATA_BITS-1:1], coords});
    noise = CFG_DATA_BITS'($urandom);
    write_reg(REG_PRECISION, {noise[CFG_DATA_BITS-1:1], prec});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_we_i   <= 1'b0;
    cur_coords  = coords;
    cur_prec    = prec;
  endtask

  // Pick a grid shape that leaves room for the nodes still to come
  task automatic random_grid();
    logic [DIM_BITS-1:0] w, h;
    int                  need;
    wait_idle();
    need = int'(nodes_seen) + HEADROOM;
    case ($urandom_range(0, 4))
      0: begin
        w = DIM_BITS'(1);
        h = DIM_BITS'(need + int'($urandom_range(0, 64)));
      end
      1: begin
        w = DIM_MAX;
        h = DIM_BITS'($urandom_range(1, DIM_MAX));
      end
      2: begin
        h = DIM_BITS'(1);
        w = DIM_BITS'(need + int'($urandom_range(0, 64)));
      end
      3: begin
        w = DIM_BITS'($urandom_range(2, 60));
        h = DIM_BITS'((need + int'(w) - 1) / int'(w) + int'($urandom_range(0, 16)));
      end
      default: begin
        w = DIM_BITS'($urandom_range(1, DIM_MAX));
        h = DIM_BITS'($urandom_range((need + int'(w) - 1) / int'(w), DIM_MAX));
      end
    endcase
    set_grid(random_order(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), w, h);
  endtask

  // Mostly complete nodes, now and then a truncated one
  task automatic run_phase(int nodes);
    for (int n = 0; n < nodes; n++) begin
      if ($urandom_range(99) < 10) send_tokens($urandom_range(1, node_tokens()));
      else send_tokens(node_tokens());
    end
  endtask

  initial begin : stimulus
    ending_e             ending;
    logic [DIM_BITS-1:0] span;
    int                  extra;
    int                  phase;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_ORDER;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    command_i        <= CMD_TOKEN;
    token_value_i    <= '0;
    quiet             = 1'b0;
    backpressure_req  = 1'b0;
    cur_coords        = 1'b0;
    cur_prec          = 1'b0;
    items_sent        = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: a 1x1 row-major grid takes one node
    send_item(CMD_TOKEN, '1);

    // The other named orders, with and without coordinates and precision
    set_grid(ORD_COL_BOTTOM, 1'b0, 1'b0, 14'd4, 14'd5);
    send_item(CMD_TOKEN, '0);
    send_item(CMD_TOKEN, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(CMD_TOKEN, 64'h5555_5555_5555_5555);
    send_item(CMD_TOKEN, '1);
    set_grid(ORD_COL_TOP, 1'b1, 1'b0, 14'd3, 14'd7);
    send_tokens(6);
    set_grid(ORD_ROWS_BOTTOM, 1'b1, 1'b1, DIM_MAX, DIM_MAX);
    send_tokens(4);

    // Undefined order codes, single-column and single-row extremes
    set_grid(ORD_CODE_ZERO, 1'b0, 1'b1, 14'd1, DIM_MAX);
    send_tokens(4);
    wait_idle();
    write_reg(REG_NONE, '1);
    cfg_we_i <= 1'b0;
    set_grid(ORD_CODE_TOP, 1'b0, 1'b0, DIM_MAX, 14'd1);
    send_tokens(2);

    // Leave a node half done, then change the layout under it
    set_grid(ORD_ROW_MAJOR, 1'b1, 1'b1, 14'd100, 14'd100);
    send_tokens(2);
    set_grid(ORD_COL_BOTTOM, 1'b0, 1'b1, 14'd100, 14'd100);
    send_tokens(3);

    // Random grids; some phases without idling, one with a long result hold-off
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      random_grid();
      quiet = (phase == QUIET_PHASE) || ($urandom_range(0, 7) == 0);
      if (phase == HOLD_PHASE) backpressure_req = 1'b1;
      run_phase((phase == QUIET_PHASE) ? 80 : $urandom_range(8, 40));
      phase++;
    end
    quiet = 1'b0;

    // Close the grid one of four ways; align to a node boundary first
    ending = ending_e'($urandom_range(0, 3));
    set_grid(random_order(), 1'b0, 1'b0, DIM_MAX, DIM_MAX);
    if (pos_seen != '0) send_item(CMD_TOKEN, token_word());
    wait_idle();
    case (ending)
      END_EXACT, END_OVERFLOW: begin
        extra = $urandom_range(1, 12);
        span  = DIM_BITS'(int'(nodes_seen) + extra);
        if ($urandom_range(0, 1)) set_grid(random_order(), 1'b0, 1'b0, span, 14'd1);
        else set_grid(random_order(), 1'b0, 1'b0, 14'd1, span);
        send_tokens(extra);
        if (ending == END_EXACT) send_item(CMD_END, token_word());
        else send_tokens($urandom_range(1, 3));
      end
      END_SHORT: begin
        send_item(CMD_END, token_word());
      end
      default: begin
        if ($urandom_range(0, 1)) set_grid(random_order(), 1'b0, 1'b0, 14'd0, DIM_MAX);
        else set_grid(random_order(), 1'b0, 1'b0, DIM_MAX, 14'd0);
        send_tokens(1);
      end
    endcase

    // Once stopped, every item reports the latched status
    for (int i = 0; i < 12; i++)
      send_item($urandom_range(0, 1) ? CMD_END : CMD_TOKEN, token_word());

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
